// ===== hw/rtl/hsvrgb_pkg.sv =====
//------------------------------------------------------------------------------
// HSV to RGB package
// Shared types, constants and the hue sector decode for the converter pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned SECT_W  = 3;
	localparam int unsigned FRAC_W  = 6;
	localparam int unsigned PROD_W  = 14;

	localparam logic [CH_W-1:0]   FULL_LEVEL = 8'd255;
	localparam logic [FRAC_W-1:0] FRAC_TOP   = 6'd42;
	localparam logic [PROD_W-1:0] SCALE_TOP  = 14'd10710;

	// x / 42 is done as (x >> 1) / 21, and the division by 21 as a multiply by
	// ceil(2^20 / 21) and a shift. The rounding error of the reciprocal times
	// the largest halved operand stays below 2^20, so the quotient is exact.
	localparam int unsigned HALF_W      = PROD_W - 1;
	localparam int unsigned RECIP_W     = 16;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 16'd49933;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RPROD_W     = HALF_W + RECIP_W;

	localparam logic [SECT_W-1:0] SECT_RED_RISE  = 3'd0;
	localparam logic [SECT_W-1:0] SECT_GRN_FALL  = 3'd1;
	localparam logic [SECT_W-1:0] SECT_GRN_RISE  = 3'd2;
	localparam logic [SECT_W-1:0] SECT_BLU_FALL  = 3'd3;
	localparam logic [SECT_W-1:0] SECT_BLU_RISE  = 3'd4;
	localparam logic [SECT_W-1:0] SECT_RED_FALL  = 3'd5;

	// Control that travels alongside the arithmetic through every stage.
	typedef struct packed {
		logic              valid;
		logic              gray;
		logic [SECT_W-1:0] sector;
		logic [CH_W-1:0]   value;
	} ctl_t;

	// Sector is hue / 43 and is found by comparing against the sector bounds.
	function automatic logic [SECT_W-1:0] hue_sector(input logic [CH_W-1:0] hue);
		logic [SECT_W-1:0] sect;
		if (hue >= 8'd215) sect = SECT_RED_FALL;
		else if (hue >= 8'd172) sect = SECT_BLU_RISE;
		else if (hue >= 8'd129) sect = SECT_BLU_FALL;
		else if (hue >= 8'd86) sect = SECT_GRN_RISE;
		else if (hue >= 8'd43) sect = SECT_GRN_FALL;
		else sect = SECT_RED_RISE;
		return sect;
	endfunction

	function automatic logic [CH_W-1:0] sector_base(input logic [SECT_W-1:0] sect);
		logic [CH_W-1:0] base;
		case (sect)
			SECT_GRN_FALL: base = 8'd43;
			SECT_GRN_RISE: base = 8'd86;
			SECT_BLU_FALL: base = 8'd129;
			SECT_BLU_RISE: base = 8'd172;
			SECT_RED_FALL: base = 8'd215;
			default:       base = 8'd0;
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hsvrgb_sector.sv =====
//------------------------------------------------------------------------------
// HSV to RGB hue decode stage
// Splits the hue into sector and position within the sector and registers
// them with saturation and value.
//------------------------------------------------------------------------------
`default_nettype none

module hsvrgb_sector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req,
	input  wire logic [hsvrgb_pkg::CH_W-1:0]   hue,
	input  wire logic [hsvrgb_pkg::CH_W-1:0]   saturation,
	input  wire logic [hsvrgb_pkg::CH_W-1:0]   brightness,
	output hsvrgb_pkg::ctl_t                   ctl_s1,
	output logic [hsvrgb_pkg::FRAC_W-1:0]      frac_s1,
	output logic [hsvrgb_pkg::CH_W-1:0]        sat_s1
);
	import hsvrgb_pkg::*;

	logic [SECT_W-1:0] sect;
	logic [CH_W-1:0]   pos;

	assign sect = hue_sector(hue);
	assign pos  = hue - sector_base(sect);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= req;
			ctl_s1.gray   <= (saturation == '0);
			ctl_s1.sector <= sect;
			ctl_s1.value  <= brightness;
		end
	end

	always_ff @(posedge clk) begin
		frac_s1 <= pos[FRAC_W-1:0];
		sat_s1  <= saturation;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hsvrgb_level.sv =====
//------------------------------------------------------------------------------
// HSV to RGB level arithmetic
// Three stages that form the low, falling and rising levels: saturation
// products, scaled division by 42, and the multiply by value.
//------------------------------------------------------------------------------
`default_nettype none

module hsvrgb_level (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hsvrgb_pkg::ctl_t              ctl_s1,
	input  wire logic [hsvrgb_pkg::FRAC_W-1:0] frac_s1,
	input  wire logic [hsvrgb_pkg::CH_W-1:0]   sat_s1,
	output hsvrgb_pkg::ctl_t                   ctl_s4,
	output logic [hsvrgb_pkg::CH_W-1:0]        low_s4,
	output logic [hsvrgb_pkg::CH_W-1:0]        fall_s4,
	output logic [hsvrgb_pkg::CH_W-1:0]        rise_s4
);
	import hsvrgb_pkg::*;

	ctl_t              ctl_s2;
	ctl_t              ctl_s3;
	logic [PROD_W-1:0] pfall_s2;
	logic [PROD_W-1:0] prise_s2;
	logic [CH_W-1:0]   low_s2;
	logic [CH_W-1:0]   low_s3;
	logic [CH_W-1:0]   qfall_s3;
	logic [CH_W-1:0]   qrise_s3;

	logic [2*CH_W-1:0]  low_prod;
	logic [HALF_W-1:0]  hfall;
	logic [HALF_W-1:0]  hrise;
	logic [RPROD_W-1:0] rfall;
	logic [RPROD_W-1:0] rrise;
	logic [2*CH_W-1:0]  vfall;
	logic [2*CH_W-1:0]  vrise;

	assign low_prod = ctl_s1.value * (FULL_LEVEL - sat_s1);

	// The numerator 10710 - p is at most 10710, so it never wraps.
	assign hfall = HALF_W'((SCALE_TOP - pfall_s2) >> 1);
	assign hrise = HALF_W'((SCALE_TOP - prise_s2) >> 1);
	assign rfall = RPROD_W'(hfall) * RPROD_W'(RECIP_MUL);
	assign rrise = RPROD_W'(hrise) * RPROD_W'(RECIP_MUL);

	assign vfall = ctl_s3.value * qfall_s3;
	assign vrise = ctl_s3.value * qrise_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		pfall_s2 <= PROD_W'(sat_s1) * PROD_W'(frac_s1);
		prise_s2 <= PROD_W'(sat_s1) * PROD_W'(FRAC_TOP - frac_s1);
		low_s2   <= low_prod[2*CH_W-1:CH_W];

		low_s3   <= low_s2;
		qfall_s3 <= rfall[RECIP_SHIFT +: CH_W];
		qrise_s3 <= rrise[RECIP_SHIFT +: CH_W];

		low_s4   <= low_s3;
		fall_s4  <= vfall[2*CH_W-1:CH_W];
		rise_s4  <= vrise[2*CH_W-1:CH_W];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hsvrgb_mix.sv =====
//------------------------------------------------------------------------------
// HSV to RGB channel mix
// Routes value and the derived levels to red, green and blue by sector and
// registers the result with its strobe.
//------------------------------------------------------------------------------
`default_nettype none

module hsvrgb_mix (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hsvrgb_pkg::ctl_t              ctl_s4,
	input  wire logic [hsvrgb_pkg::CH_W-1:0]   low_s4,
	input  wire logic [hsvrgb_pkg::CH_W-1:0]   fall_s4,
	input  wire logic [hsvrgb_pkg::CH_W-1:0]   rise_s4,
	output logic                               done_s5,
	output logic [hsvrgb_pkg::CH_W-1:0]        red_s5,
	output logic [hsvrgb_pkg::CH_W-1:0]        green_s5,
	output logic [hsvrgb_pkg::CH_W-1:0]        blue_s5
);
	import hsvrgb_pkg::*;

	logic [CH_W-1:0] r;
	logic [CH_W-1:0] g;
	logic [CH_W-1:0] b;
	logic [CH_W-1:0] v;

	assign v = ctl_s4.value;

	always_comb begin
		case (ctl_s4.sector)
			SECT_RED_RISE: begin r = v;       g = rise_s4; b = low_s4;  end
			SECT_GRN_FALL: begin r = fall_s4; g = v;       b = low_s4;  end
			SECT_GRN_RISE: begin r = low_s4;  g = v;       b = rise_s4; end
			SECT_BLU_FALL: begin r = low_s4;  g = fall_s4; b = v;       end
			SECT_BLU_RISE: begin r = rise_s4; g = low_s4;  b = v;       end
			default:       begin r = v;       g = low_s4;  b = fall_s4; end
		endcase
		// Zero saturation is plain gray and overrides the sector levels.
		if (ctl_s4.gray) begin
			r = v;
			g = v;
			b = v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		red_s5   <= r;
		green_s5 <= g;
		blue_s5  <= b;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
//------------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline from 8-bit hue, saturation and value to 8-bit RGB.
//
//   channel   handshake        payload
//   request   start / busy     hue, saturation, brightness
//   result    done (strobe)    red, green, blue
//
// One request is taken every clock cycle; busy stays low.
// A result passes the decode, level and mix registers and shows for one cycle with done.
// The stages hold, in order, the decode, the saturation multiply,
// the reciprocal multiply for the division by 42, the value multiply and
// the channel mix, each in a stage of its own.
// Reset clears the stage control words only; nothing is kept between requests.
//------------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [hsvrgb_pkg::CH_W-1:0] hue,
	input  wire logic [hsvrgb_pkg::CH_W-1:0] saturation,
	input  wire logic [hsvrgb_pkg::CH_W-1:0] brightness,
	output logic                             done,
	output logic [hsvrgb_pkg::CH_W-1:0]      red,
	output logic [hsvrgb_pkg::CH_W-1:0]      green,
	output logic [hsvrgb_pkg::CH_W-1:0]      blue
);
	import hsvrgb_pkg::*;

	ctl_t              ctl_s1;
	ctl_t              ctl_s4;
	logic [FRAC_W-1:0] frac_s1;
	logic [CH_W-1:0]   sat_s1;
	logic [CH_W-1:0]   low_s4;
	logic [CH_W-1:0]   fall_s4;
	logic [CH_W-1:0]   rise_s4;
	logic              req;

	assign busy = 1'b0;
	assign req  = start && !busy;

	hsvrgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.ctl_s1     (ctl_s1),
		.frac_s1    (frac_s1),
		.sat_s1     (sat_s1)
	);

	hsvrgb_level u_level (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.frac_s1 (frac_s1),
		.sat_s1  (sat_s1),
		.ctl_s4  (ctl_s4),
		.low_s4  (low_s4),
		.fall_s4 (fall_s4),
		.rise_s4 (rise_s4)
	);

	hsvrgb_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s4   (ctl_s4),
		.low_s4   (low_s4),
		.fall_s4  (fall_s4),
		.rise_s4  (rise_s4),
		.done_s5  (done),
		.red_s5   (red),
		.green_s5 (green),
		.blue_s5  (blue)
	);

	// Every request taken out of reset gives exactly one strobe when it leaves the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) &&
		 $past(arst_n, 4) && $past(arst_n, 5)) |-> (done == $past(req, 5)))
		else $error("result strobe does not match request five cycles earlier");

	// One channel always carries the requested value unchanged.
	a_value_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(arst_n, 5)) |->
		(red == $past(brightness, 5) || green == $past(brightness, 5) ||
		 blue == $past(brightness, 5)))
		else $error("no channel carries the requested value");

	// Gray requests give three equal channels.
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(arst_n, 5) && $past(saturation == '0, 5)) |->
		(red == green && green == blue))
		else $error("zero saturation did not give gray");

endmodule

`default_nettype wire
